FILE: design/address_range_overlay_run_merge_macros.svh
// assertion macros for the checker file of the range overlay block
// no dependencies; pulled in by `include where assertions are written
`ifndef ADDRESS_RANGE_OVERLAY_RUN_MERGE_MACROS_SVH
`define ADDRESS_RANGE_OVERLAY_RUN_MERGE_MACROS_SVH

// same-cycle implication, off while reset is high
`define ARORM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ARORM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define ARORM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/arorm_pkg.sv
// shared types and constants of the address range overlay block
// no dependencies; imported by the top level and the checker
`default_nettype none

package arorm_pkg;

   localparam int DEPTH   = 65536;
   localparam int SLOTS   = 8;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int ENTRY_W = SLOTS * 8;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SCAN   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] range_first;
      logic [31:0] range_last;
      logic [7:0]  region_code;
   } req_type;

   typedef struct packed {
      logic [31:0] run_first;
      logic [31:0] run_last;
      logic [7:0]  slot_zero;
      logic [7:0]  slot_one;
      logic [7:0]  slot_two;
      logic [7:0]  slot_three;
      logic [7:0]  slot_four;
      logic [7:0]  slot_five;
      logic [7:0]  slot_six;
      logic [7:0]  slot_seven;
      logic        final_of_item;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INS_SETUP,
      ST_INS_RD,
      ST_INS_WR,
      ST_SCAN_EVAL,
      ST_EMIT2
   } state_type;

endpackage

`default_nettype wire

FILE: design/address_range_overlay_run_merge.sv
// range overlay table with run merge over one slot ram; depends on arorm_pkg and arorm_ram
// insert: busy through a setup state, then a read and a write state per entry left after clipping
// scan: busy in an evaluate state, plus an emit state with two results; no new scan while busy
// clear: busy while every entry of the table is zeroed, one entry zeroed per cycle
// reset: synchronous; afterwards a clearing pass over every entry holds busy high
// results are single-cycle strobes; the receiver cannot stall
`default_nettype none

module address_range_overlay_run_merge (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire arorm_pkg::req_type req_data,
   output logic                   rsp_valid,
   output arorm_pkg::rsp_type     rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);

   import arorm_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // control and run state
   state_type          state_ff, state_in;
   logic [31:0]        window_base_ff;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [ENTRY_W-1:0] run_slots_ff, run_slots_in;
   logic [IDX_W-1:0]   run_start_ff, run_start_in;
   // walking index for inserts and clears, and the insert end
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   // held request and registered result
   req_type            req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // ram controls
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;

   // insert clipping, 33 bits so the window end never wraps
   logic [32:0]        base33, win_last33, first33, last33, lo33, hi33;
   logic [IDX_W-1:0]   lo_idx, hi_idx;
   logic               ins_ok;

   // scan evaluation
   logic               run_diff, emit_one, emit_two, at_last;
   logic [ENTRY_W-1:0] new_slots;
   logic [IDX_W-1:0]   new_start;

   // slot fill for the read-modify-write
   logic [ENTRY_W-1:0] filled;

   function automatic rsp_type make_rsp(input logic [31:0]        first,
                                        input logic [31:0]        last,
                                        input logic [ENTRY_W-1:0] slots,
                                        input logic               fin);
      rsp_type     r;
      logic [63:0] wide;
      wide            = 64'(slots);  // slots at and above SLOTS read as zero
      r.run_first     = first;
      r.run_last      = last;
      r.slot_zero     = wide[7:0];
      r.slot_one      = wide[15:8];
      r.slot_two      = wide[23:16];
      r.slot_three    = wide[31:24];
      r.slot_four     = wide[39:32];
      r.slot_five     = wide[47:40];
      r.slot_six      = wide[55:48];
      r.slot_seven    = wide[63:56];
      r.final_of_item = fin;
      return r;
   endfunction

   arorm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // clip the held insert range to the window
   always_comb begin
      base33     = {1'b0, window_base_ff};
      win_last33 = base33 + 33'(DEPTH - 1);
      first33    = {1'b0, req_ff.range_first};
      last33     = {1'b0, req_ff.range_last};
      lo33       = (first33 > base33) ? first33 : base33;
      hi33       = (last33 < win_last33) ? last33 : win_last33;
      lo_idx     = IDX_W'(lo33 - base33);
      hi_idx     = IDX_W'(hi33 - base33);
      // a reversed range always ends up with lo above hi here
      ins_ok     = (req_ff.region_code != 8'd0) && (lo33 <= hi33);
   end

   // first empty slot takes the code, a full entry drops it
   always_comb begin
      logic found;
      found  = 1'b0;
      filled = ram_rd_data;
      for (int j = 0; j < SLOTS; j++) begin
         if (!found && (ram_rd_data[8*j +: 8] == 8'd0)) begin
            filled[8*j +: 8] = req_ff.region_code;
            found            = 1'b1;
         end
      end
   end

   // run merge decisions for the entry just read
   always_comb begin
      run_diff  = (ram_rd_data != run_slots_ff);
      new_slots = run_diff ? ram_rd_data : run_slots_ff;
      new_start = run_diff ? scan_idx_ff : run_start_ff;
      at_last   = (scan_idx_ff == LAST_IDX);
      emit_one  = run_diff && (scan_idx_ff != '0) && (run_slots_ff != '0);
      emit_two  = at_last && (new_slots != '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  OP_INSERT: state_in = ST_INS_SETUP;
                  OP_SCAN:   state_in = ST_SCAN_EVAL;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (cur_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_INS_SETUP: state_in = ins_ok ? ST_INS_RD : ST_IDLE;
         ST_INS_RD:    state_in = ST_INS_WR;
         ST_INS_WR:    state_in = (cur_ff == hi_ff) ? ST_IDLE : ST_INS_RD;
         ST_SCAN_EVAL: state_in = (emit_one && emit_two) ? ST_EMIT2 : ST_IDLE;
         ST_EMIT2:     state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      run_slots_in = run_slots_ff;
      run_start_in = run_start_ff;
      cur_in       = cur_ff;
      hi_in        = hi_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_idx_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff;
      ram_wr_data  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               cur_in = '0;
               // scan reads its entry right away
               if (req_data.opcode == OP_SCAN) begin
                  ram_rd_en = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            cur_in    = cur_ff + IDX_W'(1);
         end
         ST_INS_SETUP: begin
            cur_in = lo_idx;
            hi_in  = hi_idx;
         end
         ST_INS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cur_ff;
         end
         ST_INS_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = filled;
            cur_in      = cur_ff + IDX_W'(1);
         end
         ST_SCAN_EVAL: begin
            if (emit_one) begin
               // finished run ends just before this entry
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(window_base_ff + 32'(run_start_ff),
                                       window_base_ff + 32'(scan_idx_ff) - 32'd1,
                                       run_slots_ff, !emit_two);
            end else if (emit_two) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(window_base_ff + 32'(new_start),
                                       window_base_ff + 32'(LAST_IDX),
                                       new_slots, 1'b1);
            end
            if (emit_one && emit_two) begin
               // hold the last run for the second result, restart after it
               run_slots_in = new_slots;
               run_start_in = new_start;
            end else if (at_last) begin
               scan_idx_in  = '0;
               run_slots_in = '0;
               run_start_in = '0;
            end else begin
               run_slots_in = new_slots;
               run_start_in = new_start;
               scan_idx_in  = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT2: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = make_rsp(window_base_ff + 32'(run_start_ff),
                                    window_base_ff + 32'(LAST_IDX),
                                    run_slots_ff, 1'b1);
            scan_idx_in  = '0;
            run_slots_in = '0;
            run_start_in = '0;
         end
         default: begin
         end
      endcase
   end

   // control registers; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         window_base_ff <= '0;
         scan_idx_ff    <= '0;
         run_slots_ff   <= '0;
         run_start_ff   <= '0;
         cur_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         run_slots_ff <= run_slots_in;
         run_start_ff <= run_start_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         // configuration transfer
         if (csr_valid && csr_ready) begin
            window_base_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   // the window only moves between items
   assign csr_ready = !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: design/arorm_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module arorm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65536,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/arorm_checker.sv
// port-level checks of the range overlay block, bound to its top level
// depends on arorm_pkg and the assertion macro header
`default_nettype none
`include "address_range_overlay_run_merge_macros.svh"

module arorm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire arorm_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire arorm_pkg::rsp_type rsp_data
);

   import arorm_pkg::*;

   logic take, take_real, rsp_mid, rsp_last;

   assign take      = start && !busy;
   assign take_real = take && (req_data.opcode == OP_INSERT ||
                               req_data.opcode == OP_SCAN ||
                               req_data.opcode == OP_CLEAR);
   assign rsp_mid   = rsp_valid && !rsp_data.final_of_item;
   assign rsp_last  = rsp_valid && rsp_data.final_of_item;

   // reset always leaves the block sweeping the store
   `ARORM_ASSERT_NXT_ALWAYS(a_reset_clears, clock, reset, busy, "no clearing pass after reset")
   // any real item makes the block busy right after its transfer
   `ARORM_ASSERT_NXT(a_item_busy, clock, reset, take_real, busy, "item did not raise busy")
   // no result can follow a transfer in the very next cycle
   `ARORM_ASSERT_NXT(a_no_early_rsp, clock, reset, take, !rsp_valid, "result too early")
   // a non-final result is followed at once by the final one
   `ARORM_ASSERT_NXT(a_second_rsp, clock, reset, rsp_mid, rsp_last, "second result missing")

endmodule

bind address_range_overlay_run_merge arorm_checker u_arorm_checker (.*);

`default_nettype wire

FILE: verif/address_range_overlay_run_merge_test.sv
// self-checking bench for the address range overlay block with run merge
// needs arorm_pkg and the block itself; predicts slot table, scan runs and window moves
`timescale 1ns / 1ps

module address_range_overlay_run_merge_test;

   import arorm_pkg::*;

   // opcode the block must treat as a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int SEG_ITEMS      = 130;     // random transfers per window setting
   localparam int TAIL_SCANS     = 60;      // scans after the last window move
   localparam int SETTLE_CYCLES  = 4;       // lets busy rise after the last transfer
   localparam int TAIL_CYCLES    = 16;      // drain time after the last result
   localparam int WATCHDOG_LIMIT = 500000;  // covers a full-window insert and a clear

   typedef struct {
      req_type req;
      bit      typed;      // row carries its own expectation
      bit      has_run;
      rsp_type run;
   } step_row;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    [31:0] csr_data;

   // mirror of the block: slot table, scan position, open run and window
   bit   [63:0]      slot_mem [DEPTH];
   logic [IDX_W-1:0] scan_pos;
   logic [63:0]      run_slots;
   logic [IDX_W-1:0] run_start;
   logic [31:0]      win_base;

   rsp_type new_runs[$];    // runs caused by the transfer just made
   rsp_type runs_due[$];    // runs still owed by the block
   step_row plan[$];        // directed stimulus

   int fail_count  = 0;
   int quiet_cycles = 0;
   rsp_type run_want;

   address_range_overlay_run_merge dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // a run in absolute addresses, using the window as it stands now
   function automatic rsp_type run_of(input logic [IDX_W-1:0] first_idx,
                                      input logic [IDX_W-1:0] last_idx,
                                      input logic [63:0] slots, input logic fin);
      rsp_type r;
      r.run_first = win_base + 32'(first_idx);
      r.run_last  = win_base + 32'(last_idx);
      {r.slot_seven, r.slot_six, r.slot_five, r.slot_four,
       r.slot_three, r.slot_two, r.slot_one, r.slot_zero} = slots;
      r.final_of_item = fin;
      return r;
   endfunction

   function automatic req_type mk_req(input logic [1:0] op, input logic [31:0] first,
                                      input logic [31:0] last, input logic [7:0] code);
      req_type r;
      r.opcode      = op;
      r.range_first = first;
      r.range_last  = last;
      r.region_code = code;
      return r;
   endfunction

   // apply one accepted transfer to the mirror and collect the runs it closes
   task automatic step_table(input req_type req);
      logic [32:0]      lo;
      logic [32:0]      hi;
      logic [32:0]      top;
      logic [32:0]      a;
      logic [IDX_W-1:0] idx;
      logic [63:0]      entry;
      bit               placed;
      rsp_type          runs [2];
      int               n;
      n = 0;
      new_runs.delete();
      case (req.opcode)
         OP_INSERT: begin
            // code zero and reversed ranges leave the table alone
            if (req.region_code != 8'd0 && req.range_first <= req.range_last) begin
               top = {1'b0, win_base} + 33'(DEPTH - 1);
               lo  = (req.range_first > win_base) ? {1'b0, req.range_first} : {1'b0, win_base};
               hi  = ({1'b0, req.range_last} < top) ? {1'b0, req.range_last} : top;
               for (a = lo; a <= hi; a++) begin
                  idx    = IDX_W'(a - {1'b0, win_base});
                  entry  = slot_mem[idx];
                  placed = 1'b0;
                  // first empty slot takes the code, a full entry drops it
                  for (int j = 0; j < SLOTS; j++) begin
                     if (!placed && entry[8*j +: 8] == 8'd0) begin
                        entry[8*j +: 8] = req.region_code;
                        placed = 1'b1;
                     end
                  end
                  slot_mem[idx] = entry;
               end
            end
         end
         OP_CLEAR: begin
            // scan position and open run survive a clear
            foreach (slot_mem[k]) slot_mem[k] = '0;
         end
         OP_SCAN: begin
            entry = slot_mem[scan_pos];
            if (entry != run_slots) begin
               if (scan_pos != '0 && run_slots != '0) begin
                  runs[n] = run_of(run_start, scan_pos - IDX_W'(1), run_slots, 1'b0);
                  n++;
               end
               run_slots = entry;
               run_start = scan_pos;
            end
            if (scan_pos == IDX_W'(DEPTH - 1)) begin
               // end of table: flush the open run and restart from entry 0
               if (run_slots != '0) begin
                  runs[n] = run_of(run_start, IDX_W'(DEPTH - 1), run_slots, 1'b0);
                  n++;
               end
               scan_pos  = '0;
               run_slots = '0;
               run_start = '0;
            end else begin
               scan_pos = scan_pos + IDX_W'(1);
            end
            if (n > 0) runs[n-1].final_of_item = 1'b1;
            for (int i = 0; i < n; i++) new_runs.push_back(runs[i]);
         end
         default: ;
      endcase
   endtask

   // one transfer, after an optional pause; start stays high between back-to-back items
   task automatic send_item(input req_type req, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      step_table(req);
   endtask

   task automatic send_checked(input req_type req, input int gap);
      send_item(req, gap);
      foreach (new_runs[i]) runs_due.push_back(new_runs[i]);
   endtask

   // window moves only with the block idle and nothing owed
   task automatic set_window(input logic [31:0] value);
      start <= 1'b0;
      while (runs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      win_base = value;
   endtask

   function automatic logic [31:0] pick_base(input int k);
      case (k % 4)
         0:       return $urandom();
         1:       return 32'hFFFF_FFFF;
         2:       return 32'hFFFF_8000;
         default: return 32'h0000_0000;
      endcase
   endfunction

   // idle cycles before the next item, each one taken with the given percentage
   function automatic int pick_gap(input int pct);
      int g;
      g = 0;
      while ($urandom_range(0, 99) < pct) g++;
      return g;
   endfunction

   // mostly scans and inserts just ahead of the scan, so scans keep closing runs
   function automatic req_type random_item();
      int          pick;
      int          len;
      logic [31:0] first;
      logic [31:0] last;
      pick = $urandom_range(0, 999);
      if (pick < 2) return mk_req(OP_CLEAR, $urandom(), $urandom(), 8'($urandom()));
      if (pick < 450) return mk_req(OP_SCAN, $urandom(), $urandom(), 8'($urandom()));
      if (pick < 880) begin
         len   = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 300) : $urandom_range(1, 8);
         first = win_base + 32'(scan_pos) + $urandom_range(0, 48);
         last  = first + 32'(len - 1);
         return mk_req(OP_INSERT, first, last, 8'($urandom_range(1, 255)));
      end
      // noise: ignored codes, reversed or stray ranges, edges of the window, unused opcode
      first = $urandom();
      case ($urandom_range(0, 4))
         0: return mk_req(OP_INSERT, first, first + $urandom_range(0, 15), 8'd0);
         1: return mk_req(OP_INSERT, first | 32'h1, (first | 32'h1) - $urandom_range(1, 1000),
                          8'($urandom_range(1, 255)));
         2: return mk_req(OP_INSERT, first, first + $urandom_range(0, 15),
                          8'($urandom_range(1, 255)));
         3: return mk_req(OP_UNUSED, first, $urandom(), 8'($urandom()));
         default: return mk_req(OP_INSERT, win_base - $urandom_range(1, 20),
                                win_base + $urandom_range(0, 10), 8'($urandom_range(1, 255)));
      endcase
   endfunction

   task automatic add_row(input req_type req, input bit typed, input bit has_run,
                          input rsp_type run);
      step_row r;
      r.req     = req;
      r.typed   = typed;
      r.has_run = has_run;
      r.run     = run;
      plan.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t %s mismatch: expected %h got %h", $time, name, want, got);
      end
   endtask

   // result side: every strobe is a transfer, the receiver never stalls
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid) begin
            if (runs_due.size() == 0) begin
               fail_count++;
               $display("%0t unexpected run: expected none got %h..%h",
                        $time, rsp_data.run_first, rsp_data.run_last);
            end else begin
               run_want = runs_due.pop_front();
               check_field("run_first",     run_want.run_first,     rsp_data.run_first);
               check_field("run_last",      run_want.run_last,      rsp_data.run_last);
               check_field("slot_zero",     run_want.slot_zero,     rsp_data.slot_zero);
               check_field("slot_one",      run_want.slot_one,      rsp_data.slot_one);
               check_field("slot_two",      run_want.slot_two,      rsp_data.slot_two);
               check_field("slot_three",    run_want.slot_three,    rsp_data.slot_three);
               check_field("slot_four",     run_want.slot_four,     rsp_data.slot_four);
               check_field("slot_five",     run_want.slot_five,     rsp_data.slot_five);
               check_field("slot_six",      run_want.slot_six,      rsp_data.slot_six);
               check_field("slot_seven",    run_want.slot_seven,    rsp_data.slot_seven);
               check_field("final_of_item", run_want.final_of_item, rsp_data.final_of_item);
            end
         end
      end
   end

   // hang guard: too long without any transfer on any port
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int          idle_pct [3];
      logic [31:0] spot;
      idle_pct = '{20, 74, 0};

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      foreach (slot_mem[k]) slot_mem[k] = '0;
      scan_pos  = '0;
      run_slots = '0;
      run_start = '0;
      win_base  = '0;

      // directed rows, window at its reset value of zero
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 0, '0);                     // empty entry 0
      add_row(mk_req(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 8'd0), 0, 0, '0); // code zero ignored
      add_row(mk_req(OP_INSERT, 32'd5, 32'd2, 8'd7), 0, 0, '0);         // reversed range
      add_row(mk_req(OP_INSERT, 32'd1, 32'd2, 8'hFF), 0, 0, '0);        // code 255 stored
      for (int c = 1; c <= 7; c++)
         add_row(mk_req(OP_INSERT, 32'd2, 32'd3, 8'(c)), 0, 0, '0);
      add_row(mk_req(OP_INSERT, 32'd2, 32'd3, 8'd8), 0, 0, '0);         // entry 2 full, dropped
      add_row(mk_req(OP_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'd9), 0, 0, '0); // outside
      add_row(mk_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF), 0, 0, '0);
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 0, '0);                     // run opens at 1
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 1, run_of(1, 1, 64'hFF, 1'b1));
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 1,
              run_of(2, 2, 64'h0706_0504_0302_01FF, 1'b1));
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 1,
              run_of(3, 3, 64'h0807_0605_0403_0201, 1'b1));
      add_row(mk_req(OP_CLEAR, 0, 0, 0), 0, 0, '0);
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 0, '0);
      add_row(mk_req(OP_INSERT, 32'd6, 32'd7, 8'hFE), 0, 0, '0);
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 0, '0);
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 0, '0);
      add_row(mk_req(OP_SCAN, 0, 0, 0), 1, 1, run_of(6, 7, 64'hFE, 1'b1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part; the block may still be in its clearing pass, start just waits
      foreach (plan[i]) begin
         send_item(plan[i].req, 0);
         if (!plan[i].typed)
            foreach (new_runs[k]) runs_due.push_back(new_runs[k]);
         else if (plan[i].has_run)
            runs_due.push_back(plan[i].run);
      end

      // random part: sender idles 20%, then 74%, then never; window moves per segment
      for (int phase = 0; phase < 3; phase++) begin
         for (int seg = 0; seg < 3; seg++) begin
            set_window(pick_base(phase * 3 + seg));
            repeat (SEG_ITEMS) send_checked(random_item(), pick_gap(idle_pct[phase]));
         end
      end

      // long insert over the whole window, marks near its end and scattered inserts,
      // then move the window so emitted addresses wrap past zero and scan on
      set_window(32'h0000_0000);
      send_checked(mk_req(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 8'h5A), 0);
      send_checked(mk_req(OP_INSERT, 32'(DEPTH - 2), 32'(DEPTH - 2), 8'h11), 0);
      send_checked(mk_req(OP_INSERT, 32'(DEPTH - 1), 32'(DEPTH - 1), 8'h22), 0);
      repeat (40) begin
         spot = $urandom_range(0, DEPTH - 1);
         send_checked(mk_req(OP_INSERT, spot, spot + $urandom_range(0, 3),
                             8'($urandom_range(1, 255))), 0);
      end
      set_window(32'hFFFF_FFF0);
      repeat (TAIL_SCANS) send_checked(mk_req(OP_SCAN, 0, 0, 0), 0);

      start <= 1'b0;
      while (runs_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
